// File: design/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg
// shared constants, command codes and the memory request bundle of the
// bounded data stack
// ----------------------------------------------------------------------------
package bds_pkg;

   // storage
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PTR_W  = $clog2(DEPTH + 1);

   // field widths
   localparam int WORD_W      = 32;
   localparam int CMD_W       = 3;
   localparam int CAP_W       = 11;
   localparam int DEPTH_OUT_W = 11;
   localparam int RSP_W       = WORD_W + 2 + DEPTH_OUT_W;
   localparam int RSP_BYTES_W = ((RSP_W + 7) / 8) * 8;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SWAP = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DUP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DROP = 3'd4;

   // one request bundle for the entry store: a write and a read
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// File: design/bounded_data_stack_core.sv
// ----------------------------------------------------------------------------
// bounded_data_stack_core
// bounded lifo of 32-bit words with push, pop, swap, dup and drop commands
// ----------------------------------------------------------------------------
// steps: each request is taken in idle and runs the execute step; dup adds
//   push2, swap adds swap_b and push2; the last step waits while the result
//   register is held; a new request is taken only after the last finishes;
//   the single read and write port of the entry store set the step count
// reset: synchronous, clears depth, sequencer and result valid; capacity
//   returns to 1024; entries are left as they are
module bounded_data_stack_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // [31:0] push_value
   input  logic [bds_pkg::CMD_W-1:0]          req_tuser,  // [2:0] command
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] popped_value, [32] push_accepted, [33] pop_was_empty,
   // [44:34] depth_now, [47:45] zero
   output logic [bds_pkg::RSP_BYTES_W-1:0]    rsp_tdata,
   // capacity register
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bds_pkg::CAP_W-1:0]          csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_SWAP_B = 4'b0100,
      ST_PUSH2  = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   logic [bds_pkg::CMD_W-1:0]         cmd_ff, cmd_in;
   logic [bds_pkg::WORD_W-1:0]        val_ff, val_in;
   logic [bds_pkg::PTR_W-1:0]         sp_ff, sp_in;
   logic [bds_pkg::PTR_W-1:0]         wp_ff, wp_in;
   logic [bds_pkg::WORD_W-1:0]        top_ff, top_in;
   logic [bds_pkg::CAP_W-1:0]         cap_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bds_pkg::RSP_BYTES_W-1:0]   rsp_data_ff, rsp_data_in;

   bds_pkg::mem_req_type              mem_req;
   logic [bds_pkg::WORD_W-1:0]        rd_data;

   logic [bds_pkg::PTR_W-1:0]         lim;
   logic [bds_pkg::PTR_W-1:0]         sp_dec;
   logic                              sp_nz;
   logic                              sp_ge2;
   logic                              out_free;
   logic                              finish;
   logic [bds_pkg::WORD_W-1:0]        popped;
   logic                              accepted;
   logic                              was_empty;
   logic [bds_pkg::WORD_W-1:0]        top_word;

   // entry store
   bds_stack_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // effective limit is the smaller of capacity and store depth
   always_comb begin
      if (32'(cap_ff) >= bds_pkg::DEPTH) begin
         lim = bds_pkg::PTR_W'(bds_pkg::DEPTH);
      end else begin
         lim = bds_pkg::PTR_W'(cap_ff);
      end
   end

   assign sp_nz    = (sp_ff != '0);
   assign sp_ge2   = (sp_ff >= bds_pkg::PTR_W'(2));
   assign sp_dec   = sp_nz ? (sp_ff - bds_pkg::PTR_W'(1)) : '0;
   // popping an empty stack yields zero
   assign top_word = sp_nz ? rd_data : '0;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      sp_in        = sp_ff;
      wp_in        = wp_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;
      finish       = 1'b0;
      popped       = '0;
      accepted     = 1'b0;
      was_empty    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // take the request and fetch the top entry straight away
            if (req_tvalid) begin
               cmd_in          = req_tuser;
               val_in          = req_tdata;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = bds_pkg::ADDR_W'(sp_ff - bds_pkg::PTR_W'(1));
               state_in        = ST_EXEC;
            end
         end

         ST_EXEC: begin
            unique case (cmd_ff)
               bds_pkg::CMD_PUSH: begin
                  if (out_free) begin
                     if (sp_ff < lim) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = bds_pkg::ADDR_W'(sp_ff);
                        mem_req.wr_data = val_ff;
                        sp_in           = sp_ff + bds_pkg::PTR_W'(1);
                        accepted        = 1'b1;
                     end
                     finish = 1'b1;
                  end
               end
               bds_pkg::CMD_POP: begin
                  if (out_free) begin
                     was_empty = !sp_nz;
                     popped    = top_word;
                     sp_in     = sp_dec;
                     finish    = 1'b1;
                  end
               end
               bds_pkg::CMD_DROP: begin
                  if (out_free) begin
                     sp_in  = sp_dec;
                     finish = 1'b1;
                  end
               end
               bds_pkg::CMD_SWAP: begin
                  // keep the first pop, fetch the entry below it
                  top_in          = top_word;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = bds_pkg::ADDR_W'(sp_ff - bds_pkg::PTR_W'(2));
                  wp_in           = sp_ge2 ? (sp_ff - bds_pkg::PTR_W'(2)) : '0;
                  state_in        = ST_SWAP_B;
               end
               bds_pkg::CMD_DUP: begin
                  // first push goes back where the pop came from
                  if (sp_dec < lim) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = bds_pkg::ADDR_W'(sp_dec);
                     mem_req.wr_data = top_word;
                     wp_in           = sp_dec + bds_pkg::PTR_W'(1);
                  end else begin
                     wp_in = sp_dec;
                  end
                  top_in   = top_word;
                  state_in = ST_PUSH2;
               end
               default: begin
                  // unused codes leave the stack alone
                  if (out_free) begin
                     finish = 1'b1;
                  end
               end
            endcase
         end

         ST_SWAP_B: begin
            // old top goes down first, second entry is kept for the last push
            if (wp_ff < lim) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = bds_pkg::ADDR_W'(wp_ff);
               mem_req.wr_data = top_ff;
               wp_in           = wp_ff + bds_pkg::PTR_W'(1);
            end
            top_in   = sp_ge2 ? rd_data : '0;
            state_in = ST_PUSH2;
         end

         ST_PUSH2: begin
            if (out_free) begin
               if (wp_ff < lim) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = bds_pkg::ADDR_W'(wp_ff);
                  mem_req.wr_data = top_ff;
                  sp_in           = wp_ff + bds_pkg::PTR_W'(1);
               end else begin
                  sp_in = wp_ff;
               end
               finish = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // load the result register and return to idle
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = bds_pkg::RSP_BYTES_W'({bds_pkg::DEPTH_OUT_W'(sp_in),
                                               was_empty, accepted, popped});
         state_in     = ST_IDLE;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         cap_ff       <= bds_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      wp_ff       <= wp_in;
      top_ff      <= top_in;
      rsp_data_ff <= rsp_data_in;
   end

   // depth never runs past the store
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= bds_pkg::PTR_W'(bds_pkg::DEPTH))
      else $error("stack pointer beyond store depth");

   // an accepted request always goes to the execute step
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("request accepted without execute step");

   // depth only moves when a command finishes
   a_idle_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(sp_ff))
      else $error("depth changed while idle");

   // a stored push leaves at least one entry
   a_push_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[bds_pkg::WORD_W])
         |-> (rsp_data_ff[bds_pkg::WORD_W+2 +: bds_pkg::DEPTH_OUT_W] != '0))
      else $error("push reported with empty stack");

endmodule

// File: design/bds_stack_mem.sv
// ----------------------------------------------------------------------------
// bds_stack_mem
// entry store: one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bds_stack_mem (
   input  logic                         clock,
   input  bds_pkg::mem_req_type         mem_req,
   output logic [bds_pkg::WORD_W-1:0]   rd_data
);

   logic [bds_pkg::WORD_W-1:0] entries [bds_pkg::DEPTH];
   logic [bds_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entries[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= entries[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
